>>> rtl/core/pecq_pkg.sv
// Package for the coalescing pointer event queue.
// Shared constants, codes and defaults; no dependencies.
package pecq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int COORD_BITS_DEF  = 12;

    localparam int CFG_W    = 13;
    localparam int POS_W    = 16;
    localparam int CMP_W    = POS_W + 1;
    localparam int ACT_W    = 2;
    localparam int IN_TDATA_W = 40;

    localparam logic [CFG_W-1:0] SCREEN_W_RST = CFG_W'(320);
    localparam logic [CFG_W-1:0] SCREEN_H_RST = CFG_W'(240);

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_POLL   = 1'b1;

    localparam logic [ACT_W-1:0] ACT_DOWN = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UP   = 2'd2;

endpackage

>>> rtl/core/pecq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pecq_ram #(
    parameter int DATA_W = 26,
    parameter int DEPTH  = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pecq_ctrl.sv
// Queue control: screen registers, bound check, pointers, coalescing and eviction.
// Depends on pecq_pkg and pecq_ram.
module pecq_ctrl #(
    parameter int QUEUE_DEPTH = pecq_pkg::QUEUE_DEPTH_DEF,
    parameter int COORD_BITS  = pecq_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [pecq_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_acc,
    input  logic                            i_mode,
    input  logic [pecq_pkg::ACT_W-1:0]      i_action,
    input  logic [pecq_pkg::POS_W-1:0]      i_pos_x,
    input  logic [pecq_pkg::POS_W-1:0]      i_pos_y,
    output logic                            o_pop,
    output logic [2*COORD_BITS+pecq_pkg::ACT_W-1:0] o_head_data
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W  = 2 * COORD_BITS + pecq_pkg::ACT_W;
    localparam logic [pecq_pkg::CMP_W-1:0] COORD_LIMIT =
        pecq_pkg::CMP_W'(1) << COORD_BITS;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [pecq_pkg::CFG_W-1:0] r_scr_w;
    logic [pecq_pkg::CFG_W-1:0] r_scr_h;
    logic [PTR_W-1:0]           r_head;
    logic [PTR_W-1:0]           r_tail;
    logic [CNT_W-1:0]           r_count;
    logic                       r_last_move;

    logic [PTR_W-1:0]           n_head;
    logic [PTR_W-1:0]           n_tail;
    logic [CNT_W-1:0]           n_count;
    logic                       n_last_move;

    logic [pecq_pkg::CMP_W-1:0] lim_x;
    logic [pecq_pkg::CMP_W-1:0] lim_y;
    logic                       sub_ok;
    logic                       is_move;
    logic                       not_empty;
    logic                       full;
    logic                       coalesce;
    logic                       poll;
    logic                       we;
    logic [PTR_W-1:0]           waddr;
    logic [PTR_W-1:0]           head_inc;
    logic [PTR_W-1:0]           tail_inc;
    logic [PTR_W-1:0]           tail_dec;
    logic [ENT_W-1:0]           wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= pecq_pkg::SCREEN_W_RST;
            r_scr_h <= pecq_pkg::SCREEN_H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pecq_pkg::CFG_IDX_WIDTH:  r_scr_w <= i_cfg_data;
                pecq_pkg::CFG_IDX_HEIGHT: r_scr_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign lim_x = (pecq_pkg::CMP_W'(r_scr_w) > COORD_LIMIT) ? COORD_LIMIT
                                                             : pecq_pkg::CMP_W'(r_scr_w);
    assign lim_y = (pecq_pkg::CMP_W'(r_scr_h) > COORD_LIMIT) ? COORD_LIMIT
                                                             : pecq_pkg::CMP_W'(r_scr_h);

    assign sub_ok = i_acc && (i_mode == pecq_pkg::MODE_SUBMIT)
                 && (i_action == pecq_pkg::ACT_DOWN || i_action == pecq_pkg::ACT_MOVE
                     || i_action == pecq_pkg::ACT_UP)
                 && !i_pos_x[pecq_pkg::POS_W-1] && !i_pos_y[pecq_pkg::POS_W-1]
                 && (pecq_pkg::CMP_W'(i_pos_x) < lim_x)
                 && (pecq_pkg::CMP_W'(i_pos_y) < lim_y);

    assign poll      = i_acc && (i_mode == pecq_pkg::MODE_POLL);
    assign is_move   = (i_action == pecq_pkg::ACT_MOVE);
    assign not_empty = (r_count != '0);
    assign full      = (r_count == CNT_FULL);
    assign coalesce  = is_move && not_empty && r_last_move;

    assign head_inc = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
    assign tail_inc = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
    assign tail_dec = (r_tail == '0) ? PTR_LAST : r_tail - PTR_W'(1);

    assign wdata = {i_action, i_pos_y[COORD_BITS-1:0], i_pos_x[COORD_BITS-1:0]};

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_last_move = r_last_move;
        we          = 1'b0;
        waddr       = r_tail;
        o_pop       = 1'b0;
        if (sub_ok) begin
            if (coalesce) begin
                we    = 1'b1;
                waddr = tail_dec;
            end else if (!(full && is_move)) begin
                we          = 1'b1;
                n_tail      = tail_inc;
                n_last_move = is_move;
                if (full) begin
                    n_head = head_inc;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end else if (poll && not_empty) begin
            o_pop   = 1'b1;
            n_head  = head_inc;
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_last_move <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_last_move <= n_last_move;
        end
    end

    pecq_ram #(
        .DATA_W (ENT_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (poll),
        .i_raddr (r_head),
        .o_rdata (o_head_data)
    );

endmodule

>>> rtl/core/pointer_event_queue_coalescing.sv
// Top level of the coalescing pointer event queue: stream ports, poll stage,
// held pointer and output register. Depends on pecq_pkg and pecq_ctrl.
//
//   port group      dir  per transaction
//   i_s_*           in   one submit or poll request
//   o_m_*           out  one held pointer sample per poll, none per submit
//   i_cfg_*         in   screen width (index 0) or height (index 1)
//
// One transaction is accepted per cycle unless stalled. For a poll, the queue head is
// read from the event RAM at acceptance, then the held point is updated into the output
// register, which presents the sample. Reset is synchronous and clears pointers, count
// and held point; the event RAM is not cleared. While the output register is full and
// not taken, a waiting poll stalls the input; otherwise input keeps flowing.
module pointer_event_queue_coalescing #(
    parameter int QUEUE_DEPTH = pecq_pkg::QUEUE_DEPTH_DEF,
    parameter int COORD_BITS  = pecq_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [pecq_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // action[1:0], pos_x[17:2], pos_y[33:18], zero fill
    input  logic [pecq_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // mode
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // point_x, point_y, pressed, zero fill
    output logic [((2*COORD_BITS+1+7)/8)*8-1:0] o_m_tdata
);

    localparam int OUT_W = ((2 * COORD_BITS + 1 + 7) / 8) * 8;
    localparam int ENT_W = 2 * COORD_BITS + pecq_pkg::ACT_W;
    localparam int X_LO  = pecq_pkg::ACT_W;
    localparam int Y_LO  = pecq_pkg::ACT_W + pecq_pkg::POS_W;

    logic                  in_acc;
    logic                  out_free;
    logic                  s1_move;
    logic                  pop;
    logic [ENT_W-1:0]      head_data;

    logic                  r_s1_valid;
    logic                  r_s1_pop;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;
    logic [COORD_BITS-1:0] r_held_x;
    logic [COORD_BITS-1:0] r_held_y;
    logic                  r_held_pressed;

    logic [COORD_BITS-1:0] n_held_x;
    logic [COORD_BITS-1:0] n_held_y;
    logic                  n_held_pressed;

    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_s_tready = !r_s1_valid || out_free;
    assign in_acc     = i_s_tvalid && o_s_tready;

    pecq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (in_acc),
        .i_mode      (i_s_tuser),
        .i_action    (i_s_tdata[pecq_pkg::ACT_W-1:0]),
        .i_pos_x     (i_s_tdata[X_LO +: pecq_pkg::POS_W]),
        .i_pos_y     (i_s_tdata[Y_LO +: pecq_pkg::POS_W]),
        .o_pop       (pop),
        .o_head_data (head_data)
    );

    always_comb begin
        n_held_x       = r_held_x;
        n_held_y       = r_held_y;
        n_held_pressed = r_held_pressed;
        if (r_s1_pop) begin
            n_held_x       = head_data[COORD_BITS-1:0];
            n_held_y       = head_data[2*COORD_BITS-1:COORD_BITS];
            n_held_pressed = (head_data[ENT_W-1:2*COORD_BITS] != pecq_pkg::ACT_UP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s1_pop       <= 1'b0;
            r_out_valid    <= 1'b0;
            r_held_x       <= '0;
            r_held_y       <= '0;
            r_held_pressed <= 1'b0;
        end else begin
            if (in_acc && i_s_tuser == pecq_pkg::MODE_POLL) begin
                r_s1_valid <= 1'b1;
                r_s1_pop   <= pop;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid    <= 1'b1;
                r_held_x       <= n_held_x;
                r_held_y       <= n_held_y;
                r_held_pressed <= n_held_pressed;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= OUT_W'({n_held_pressed, n_held_y, n_held_x});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
